// ----- design/gq_identification_verify_assert.svh -----
// Assertion macros shared by the verifier's RTL modules.
// Included by the modules that carry concurrent assertions; depends on nothing.
`ifndef GQ_IDENTIFICATION_VERIFY_ASSERT_SVH
`define GQ_IDENTIFICATION_VERIFY_ASSERT_SVH

// Clocked assertion that is switched off while reset is applied.
`define GQV_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked at every edge, reset included.
`define GQV_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/gqv_pkg.sv -----
// Types and constants of the identification verifier.
// Used by every module of the block; depends on nothing.
package gqv_pkg;

  localparam int unsigned ADDR_BITS = 3;
  localparam int unsigned DATA_BITS = 32;

  // Register indexes, taken from paddr[2].
  localparam logic REG_MODULUS  = 1'b0;
  localparam logic REG_EXPONENT = 1'b1;

  localparam logic [DATA_BITS-1:0] MODULUS_RESET  = 32'd101;
  localparam logic [DATA_BITS-1:0] EXPONENT_RESET = 32'd5;

  typedef struct packed {
    logic [DATA_BITS-1:0] modulus;
    logic [DATA_BITS-1:0] exponent;
  } gqv_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } gqv_mm_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_OUT
  } gqv_state_e;

  // Operation handed to the modular multiplier.
  typedef enum logic [1:0] {
    OP_RED,
    OP_SQR,
    OP_MULB,
    OP_FIN
  } gqv_op_e;

endpackage

// ----- design/gqv_apb.sv -----
// Configuration registers of the verifier behind an APB-style port.
// Depends on gqv_pkg.
module gqv_apb (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gqv_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [gqv_pkg::DATA_BITS-1:0]  pwdata,
  output logic [gqv_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  output gqv_pkg::gqv_cfg_t              cfg_o
);
  import gqv_pkg::*;

  gqv_cfg_t cfg_q, cfg_d;
  logic     wr_en;
  logic     reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_MODULUS:  cfg_d.modulus  = pwdata;
        REG_EXPONENT: cfg_d.exponent = pwdata;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MODULUS:  prdata = cfg_q.modulus;
      REG_EXPONENT: prdata = cfg_q.exponent;
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.modulus  <= MODULUS_RESET;
      cfg_q.exponent <= EXPONENT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/gqv_modmul.sv -----
// Bit-serial shift-add modular multiplier: one bit of b per cycle, top bit first.
// Depends on gqv_pkg and the assertion header.
`include "gq_identification_verify_assert.svh"

module gqv_modmul #(
  parameter int unsigned W = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [W-1:0]          a_i,
  input  logic [W-1:0]          b_i,
  input  logic [W-1:0]          n_i,
  output logic [W-1:0]          res_o,
  output gqv_pkg::gqv_mm_stat_t stat_o
);
  import gqv_pkg::*;

  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  a_q, a_d;
  logic [W-1:0]  b_q, b_d;
  logic [W-1:0]  acc_q, acc_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;

  logic [W:0]    n_x;
  logic [W:0]    dbl, dbl_red;
  logic [W:0]    sum, sum_red;
  logic [W-1:0]  acc_next;

  // Both adds keep the accumulator below n, so one conditional subtract suffices.
  assign n_x     = {1'b0, n_i};
  assign dbl     = {1'b0, acc_q} + {1'b0, acc_q};
  assign dbl_red = (dbl >= n_x) ? (dbl - n_x) : dbl;
  assign sum     = {1'b0, dbl_red[W-1:0]} + {1'b0, a_q};
  assign sum_red = (sum >= n_x) ? (sum - n_x) : sum;
  assign acc_next = b_q[W-1] ? sum_red[W-1:0] : dbl_red[W-1:0];

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
      cnt_d  = CW'(W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = acc_next;
      b_d   = b_q << 1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign res_o       = acc_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  `GQV_ASSERT(a_mm_start_idle, clk_i, rst_ni, start_i |-> !busy_q, "multiplier restarted while busy")
  `GQV_ASSERT(a_mm_start_busy, clk_i, rst_ni, start_i |=> busy_q, "multiplier did not start")
  `GQV_ASSERT(a_mm_done_end, clk_i, rst_ni, done_q |-> ($past(busy_q) && !busy_q),
              "done without a finished run")

endmodule

// ----- design/gqv_seq.sv -----
// Sequencer of the verifier: reductions, two square-and-multiply exponentiations
// and the final product on the shared multiplier. Depends on gqv_pkg and the assertion header.
`include "gq_identification_verify_assert.svh"

module gqv_seq #(
  parameter int unsigned W = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [W-1:0]          n_i,
  input  logic [W-1:0]          e_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [W-1:0]          v_i,
  input  logic [W-1:0]          x_i,
  input  logic [W-1:0]          c_i,
  input  logic [W-1:0]          y_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  granted_o,
  output logic [W-1:0]          result_o,
  output logic                  mm_start_o,
  output logic [W-1:0]          mm_a_o,
  output logic [W-1:0]          mm_b_o,
  input  logic [W-1:0]          mm_res_i,
  input  gqv_pkg::gqv_mm_stat_t mm_stat_i
);
  import gqv_pkg::*;

  localparam int unsigned CW = $clog2(W);

  gqv_state_e    state_q, state_d;
  gqv_op_e       op_q, op_d;
  logic          pass_q, pass_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;

  logic [W-1:0]  v_q, v_d, x_q, x_d, c_q, c_d, y_q, y_d;
  logic [W-1:0]  acc_q, acc_d, base_q, base_d, t_q, t_d;
  logic [W-1:0]  exp_q, exp_d, r_q, r_d;
  logic          granted_q, granted_d;
  logic [W-1:0]  res_q, res_d;

  logic [W-1:0]  one;

  // The residue of one is zero for a modulus of one.
  assign one = (n_i == W'(1)) ? '0 : W'(1);

  always_comb begin
    unique case (op_q)
      OP_RED: begin
        // Multiplying one by a raw word reduces that word modulo n.
        mm_a_o = one;
        mm_b_o = pass_q ? v_q : y_q;
      end
      OP_SQR: begin
        mm_a_o = acc_q;
        mm_b_o = acc_q;
      end
      OP_MULB: begin
        mm_a_o = acc_q;
        mm_b_o = base_q;
      end
      OP_FIN: begin
        mm_a_o = t_q;
        mm_b_o = acc_q;
      end
      default: begin
        mm_a_o = '0;
        mm_b_o = '0;
      end
    endcase
  end

  always_comb begin
    logic step;
    step        = 1'b0;
    state_d     = state_q;
    op_d        = op_q;
    pass_d      = pass_q;
    cnt_d       = cnt_q;
    v_d         = v_q;
    x_d         = x_q;
    c_d         = c_q;
    y_d         = y_q;
    acc_d       = acc_q;
    base_d      = base_q;
    t_d         = t_q;
    exp_d       = exp_q;
    r_d         = r_q;
    granted_d   = granted_q;
    res_d       = res_q;
    in_ready_o  = 1'b0;
    mm_start_o  = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          v_d    = v_i;
          x_d    = x_i;
          c_d    = c_i;
          y_d    = y_i;
          pass_d = 1'b0;
          op_d   = OP_RED;
          r_d    = '0;
          // Without a modulus nothing is reduced and the product stays zero.
          state_d = (n_i == '0) ? ST_OUT : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        mm_start_o = 1'b1;
        state_d    = ST_WAIT;
      end
      ST_WAIT: begin
        if (mm_stat_i.done) begin
          unique case (op_q)
            OP_RED: begin
              base_d  = mm_res_i;
              acc_d   = one;
              exp_d   = pass_q ? c_q : e_i;
              cnt_d   = CW'(W - 1);
              op_d    = OP_SQR;
              state_d = ST_ISSUE;
            end
            OP_SQR: begin
              acc_d = mm_res_i;
              if (exp_q[W-1]) begin
                op_d    = OP_MULB;
                state_d = ST_ISSUE;
              end else begin
                step = 1'b1;
              end
            end
            OP_MULB: begin
              acc_d = mm_res_i;
              step  = 1'b1;
            end
            OP_FIN: begin
              r_d     = mm_res_i;
              state_d = ST_OUT;
            end
            default: begin
              state_d = ST_OUT;
            end
          endcase
          if (step) begin
            exp_d   = exp_q << 1;
            state_d = ST_ISSUE;
            if (cnt_q == '0) begin
              if (!pass_q) begin
                t_d    = acc_d;
                pass_d = 1'b1;
                op_d   = OP_RED;
              end else begin
                op_d = OP_FIN;
              end
            end else begin
              cnt_d = cnt_q - CW'(1);
              op_d  = OP_SQR;
            end
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          granted_d   = (r_q == x_q);
          res_d       = r_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_RED;
      pass_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      pass_q      <= pass_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q       <= v_d;
    x_q       <= x_d;
    c_q       <= c_d;
    y_q       <= y_d;
    acc_q     <= acc_d;
    base_q    <= base_d;
    t_q       <= t_d;
    exp_q     <= exp_d;
    r_q       <= r_d;
    granted_q <= granted_d;
    res_q     <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign granted_o   = granted_q;
  assign result_o    = res_q;

  `GQV_ASSERT(a_wait_mm_active, clk_i, rst_ni,
              (state_q == ST_WAIT) |-> (mm_stat_i.busy || mm_stat_i.done),
              "waiting on an idle multiplier")
  `GQV_ASSERT(a_accept_starts, clk_i, rst_ni,
              (in_valid_i && in_ready_o) |=> (state_q == ST_ISSUE || state_q == ST_OUT),
              "accepted word did not start work")
  `GQV_ASSERT_NR(a_out_from_done, clk_i, $rose(out_valid_q) |-> $past(state_q == ST_OUT),
                 "result shown without finished work")

endmodule

// ----- design/gq_identification_verify.sv -----
// Channel     | handshake                 | payload
// ------------+---------------------------+--------------------------------------------
// input word  | in_valid_i / in_ready_o   | prover_key_i, witness_i, challenge_i,
//             |                           | response_i
// result word | out_valid_o / out_ready_i | granted_o, recomputed_o
// config      | psel, penable, pwrite     | paddr, pwdata, prdata (pready tied high)
//
// The work runs on the single bit-serial modular multiplier, one bit of its operand a cycle;
// a modulus of zero skips the multiplier and goes straight to the output.
// Reset is asynchronous and active low; it restores modulus 101 and exponent 5.
// A new word is taken once the previous result sits in the output register, even if it is
// still stalled there; a stalled result only delays handing over the next one.
module gq_identification_verify #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gqv_pkg::ADDR_BITS-1:0] paddr,
  input  logic [gqv_pkg::DATA_BITS-1:0] pwdata,
  output logic [gqv_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [31:0]                   prover_key_i,
  input  logic [31:0]                   witness_i,
  input  logic [31:0]                   challenge_i,
  input  logic [31:0]                   response_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          granted_o,
  output logic [31:0]                   recomputed_o
);
  import gqv_pkg::*;

  localparam int unsigned W = WORD_BITS;

  gqv_cfg_t     cfg;
  gqv_mm_stat_t mm_stat;
  logic         mm_start;
  logic [W-1:0] mm_a, mm_b, mm_res;
  logic [W-1:0] result;

  // Fields are 32 bits wide; the arithmetic runs on WORD_BITS-bit words.
  logic [W+31:0] n_ext, e_ext, v_ext, x_ext, c_ext, y_ext;
  logic [W+31:0] r_ext;

  assign n_ext = {W'(0), cfg.modulus};
  assign e_ext = {W'(0), cfg.exponent};
  assign v_ext = {W'(0), prover_key_i};
  assign x_ext = {W'(0), witness_i};
  assign c_ext = {W'(0), challenge_i};
  assign y_ext = {W'(0), response_i};
  assign r_ext = {32'(0), result};
  assign recomputed_o = r_ext[31:0];

  gqv_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gqv_seq #(
    .W (W)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_i         (n_ext[W-1:0]),
    .e_i         (e_ext[W-1:0]),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .v_i         (v_ext[W-1:0]),
    .x_i         (x_ext[W-1:0]),
    .c_i         (c_ext[W-1:0]),
    .y_i         (y_ext[W-1:0]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .granted_o   (granted_o),
    .result_o    (result),
    .mm_start_o  (mm_start),
    .mm_a_o      (mm_a),
    .mm_b_o      (mm_b),
    .mm_res_i    (mm_res),
    .mm_stat_i   (mm_stat)
  );

  gqv_modmul #(
    .W (W)
  ) u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .a_i     (mm_a),
    .b_i     (mm_b),
    .n_i     (n_ext[W-1:0]),
    .res_o   (mm_res),
    .stat_o  (mm_stat)
  );

endmodule
